// File: hdl/mfa_pkg.sv
package mfa_pkg;

	localparam int SLOT_BITS   = 3;
	localparam int AMOUNT_BITS = 16;
	localparam int COUNT_BITS  = 4;
	localparam int MODE_BITS   = 2;
	localparam int TDATA_BITS  = 24;

	typedef enum logic [MODE_BITS-1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NEXT  = 2'd3
	} fit_mode_t;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	localparam logic REG_FIT_MODE      = 1'b0;
	localparam logic REG_BLOCKS_IN_USE = 1'b1;

	localparam logic [COUNT_BITS-1:0] BLOCKS_IN_USE_RESET = 4'd8;

	typedef struct packed {
		fit_mode_t             fit_mode;
		logic [COUNT_BITS-1:0] blocks_in_use;
	} cfg_t;

	typedef struct packed {
		logic                   opcode;
		logic [SLOT_BITS-1:0]   block_slot;
		logic [AMOUNT_BITS-1:0] amount;
		logic                   last_request;
	} item_t;

	typedef struct packed {
		logic                   granted;
		logic [SLOT_BITS-1:0]   chosen_block;
		logic [AMOUNT_BITS-1:0] left_over;
	} result_t;

endpackage

// File: hdl/mfa_ram.sv
module mfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/mfa_ctrl.sv
module mfa_ctrl #(
	parameter int NUM_BLOCKS = 8,
	parameter int SIZE_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mfa_pkg::cfg_t    cfg,
	input  logic             item_valid,
	input  mfa_pkg::item_t   item,
	output logic             item_ready,
	output logic             res_valid,
	output mfa_pkg::result_t res,
	input  logic             res_ready
);

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t               state_q;
	logic [SIZE_BITS-1:0] need_q;
	logic                 last_q;
	logic [CW-1:0]        n_q;
	logic [IW-1:0]        pos_q;
	logic [CW-1:0]        cnt_q;
	logic                 found_q;
	logic [IW-1:0]        sel_q;
	logic [SIZE_BITS-1:0] sel_size_q;
	logic                 eval_s1;
	logic [IW-1:0]        idx_s1;
	logic [IW-1:0]        start_q;

	logic                 accept;
	logic [CW-1:0]        n_cfg;
	logic [IW-1:0]        start_pos;
	logic [IW-1:0]        pos_next;
	logic                 issue;
	logic                 take;
	logic [SIZE_BITS-1:0] diff;
	logic                 ram_we;
	logic [IW-1:0]        ram_waddr;
	logic [SIZE_BITS-1:0] ram_wdata;
	logic [SIZE_BITS-1:0] ram_rdata;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;

	always_comb begin
		if (32'(cfg.blocks_in_use) > NUM_BLOCKS) begin
			n_cfg = CW'(NUM_BLOCKS);
		end else begin
			n_cfg = CW'(cfg.blocks_in_use);
		end
	end

	assign start_pos = (cfg.fit_mode == mfa_pkg::FIT_NEXT && CW'(start_q) < n_cfg) ?
		start_q : '0;
	assign pos_next  = (CW'(pos_q) + CW'(1) == n_q) ? '0 : pos_q + IW'(1);
	assign issue     = (state_q == ST_SCAN) && (cnt_q < n_q);

	assign take = eval_s1 && (ram_rdata >= need_q) &&
		(!found_q ||
		 (cfg.fit_mode == mfa_pkg::FIT_BEST  && ram_rdata <= sel_size_q) ||
		 (cfg.fit_mode == mfa_pkg::FIT_WORST && ram_rdata >  sel_size_q));

	assign diff = sel_size_q - need_q;

	always_comb begin
		if (state_q == ST_WRITE) begin
			ram_we    = found_q;
			ram_waddr = sel_q;
			ram_wdata = diff;
		end else begin
			ram_we    = accept && item.opcode == mfa_pkg::OP_LOAD &&
				32'(item.block_slot) < NUM_BLOCKS;
			ram_waddr = IW'(item.block_slot);
			ram_wdata = SIZE_BITS'(item.amount);
		end
	end

	mfa_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(NUM_BLOCKS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	assign res_valid = (state_q == ST_WRITE);
	always_comb begin
		res.granted      = found_q;
		res.chosen_block = found_q ? mfa_pkg::SLOT_BITS'(sel_q) : '0;
		res.left_over    = found_q ? mfa_pkg::AMOUNT_BITS'(diff) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			need_q     <= '0;
			last_q     <= 1'b0;
			n_q        <= '0;
			pos_q      <= '0;
			cnt_q      <= '0;
			found_q    <= 1'b0;
			sel_q      <= '0;
			sel_size_q <= '0;
			eval_s1    <= 1'b0;
			idx_s1     <= '0;
			start_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && item.opcode == mfa_pkg::OP_REQUEST) begin
						need_q  <= SIZE_BITS'(item.amount);
						last_q  <= item.last_request;
						n_q     <= n_cfg;
						pos_q   <= start_pos;
						cnt_q   <= '0;
						found_q <= 1'b0;
						eval_s1 <= 1'b0;
						state_q <= (n_cfg == '0) ? ST_WRITE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					eval_s1 <= issue;
					idx_s1  <= pos_q;
					if (issue) begin
						pos_q <= pos_next;
						cnt_q <= cnt_q + CW'(1);
					end
					if (take) begin
						found_q    <= 1'b1;
						sel_q      <= idx_s1;
						sel_size_q <= ram_rdata;
					end
					if (cnt_q == n_q) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					eval_s1 <= 1'b0;
					if (res_ready) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							start_q <= '0;
						end else if (cfg.fit_mode == mfa_pkg::FIT_NEXT && found_q) begin
							start_q <= sel_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/memory_fit_allocator.sv
// A load transaction writes its block when accepted and yields no result.
// A request scans the first n blocks, where n is the in-use count capped at NUM_BLOCKS (no
// scan when n is zero): one block is read per cycle, the last read is then judged, and the
// write state writes the chosen block back and registers the result in the output register.
// No new transaction is taken before that, and a result that waits on m_tready delays it.
// Reset sets first fit, an in-use count of 8, a zero next-fit pointer and an empty output.
module memory_fit_allocator #(
	parameter int NUM_BLOCKS = 8,
	parameter int SIZE_BITS  = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [mfa_pkg::TDATA_BITS-1:0]          s_tdata,  // block_slot, amount
	input  logic [0:0]                              s_tuser,  // opcode
	input  logic                                    s_tlast,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [mfa_pkg::TDATA_BITS-1:0]          m_tdata,  // chosen_block, left_over
	output logic [0:0]                              m_tuser,  // granted
	input  logic                                    cfg_we,
	input  logic                                    cfg_index,
	input  logic [mfa_pkg::COUNT_BITS-1:0]          cfg_data
);

	mfa_pkg::fit_mode_t                fit_mode_q;
	logic [mfa_pkg::COUNT_BITS-1:0]    blocks_in_use_q;
	logic                              out_valid_q;
	mfa_pkg::result_t                  out_q;

	mfa_pkg::cfg_t    cfg;
	mfa_pkg::item_t   item;
	mfa_pkg::result_t res;
	logic             res_valid;
	logic             res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q      <= mfa_pkg::FIT_FIRST;
			blocks_in_use_q <= mfa_pkg::BLOCKS_IN_USE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mfa_pkg::REG_FIT_MODE: begin
					fit_mode_q <= mfa_pkg::fit_mode_t'(cfg_data[mfa_pkg::MODE_BITS-1:0]);
				end
				mfa_pkg::REG_BLOCKS_IN_USE: begin
					blocks_in_use_q <= cfg_data;
				end
				default: begin
					fit_mode_q <= fit_mode_q;
				end
			endcase
		end
	end

	always_comb begin
		cfg.fit_mode      = fit_mode_q;
		cfg.blocks_in_use = blocks_in_use_q;
		item.opcode       = s_tuser[0];
		item.block_slot   = s_tdata[mfa_pkg::SLOT_BITS-1:0];
		item.amount       = s_tdata[mfa_pkg::SLOT_BITS +: mfa_pkg::AMOUNT_BITS];
		item.last_request = s_tlast;
	end

	mfa_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item_valid(s_tvalid),
		.item      (item),
		.item_ready(s_tready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.granted;
	assign m_tdata  = mfa_pkg::TDATA_BITS'({out_q.left_over, out_q.chosen_block});

endmodule

// File: hdl/mfa_checker.sv
module mfa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [mfa_pkg::TDATA_BITS-1:0] s_tdata,
	input logic [0:0]                     s_tuser,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [mfa_pkg::TDATA_BITS-1:0] m_tdata,
	input logic [0:0]                     m_tuser,
	input logic                           cfg_we,
	input logic                           cfg_index,
	input logic [mfa_pkg::COUNT_BITS-1:0] cfg_data
);

	// A stalled result transaction must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A refused request reports zero block and zero remainder.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("refused result carries data");

	// An accepted request transaction is followed by a stall on the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == mfa_pkg::OP_REQUEST |=> !s_tready)
		else $error("input accepted during a search");

	// A load transaction completes at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == mfa_pkg::OP_LOAD |=> s_tready)
		else $error("load stalled the input");

	// A new result only appears while a search is occupying the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without a request");

endmodule

bind memory_fit_allocator mfa_checker u_mfa_checker (.*);

// File: dv/tb_memory_fit_allocator.sv
module tb_memory_fit_allocator;

	localparam int BLOCKS         = 8;
	localparam int CLK_PERIOD     = 20;
	localparam int SETTLE_CYCLES  = BLOCKS + 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 55;
	localparam int HOLD_PHASE     = 2;
	localparam int TIMEOUT_CYCLES = 400_000;

	typedef struct {
		logic                           is_cfg;
		logic                           reg_idx;
		logic [mfa_pkg::COUNT_BITS-1:0] reg_val;
		mfa_pkg::item_t                 it;
		logic                           typed;
		mfa_pkg::result_t               want;
	} plan_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [mfa_pkg::TDATA_BITS-1:0] s_tdata;
	logic [0:0]                     s_tuser;
	logic                           s_tlast;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [mfa_pkg::TDATA_BITS-1:0] m_tdata;
	logic [0:0]                     m_tuser;
	logic                           cfg_we;
	logic                           cfg_index;
	logic [mfa_pkg::COUNT_BITS-1:0] cfg_data;

	logic [mfa_pkg::AMOUNT_BITS-1:0] blk_free [BLOCKS];
	logic [mfa_pkg::SLOT_BITS-1:0]   next_ptr;
	mfa_pkg::fit_mode_t              cur_mode;
	logic [mfa_pkg::COUNT_BITS-1:0]  cur_count;

	mfa_pkg::result_t replies_due [$];
	plan_row_t        plan [$];
	mfa_pkg::result_t seen_reply;
	mfa_pkg::result_t due_reply;

	logic steady  = 1'b0;
	logic hold_rx = 1'b0;
	int   mismatches = 0;
	int   replies_checked = 0;
	int   grants_seen = 0;
	int   loads_sent = 0;
	int   requests_sent = 0;
	int   cfg_writes = 0;

	logic [mfa_pkg::COUNT_BITS-1:0] phase_counts [PHASES] = '{
		4'd8, 4'd8, 4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd9, 4'd5, 4'd8, 4'd2
	};

	memory_fit_allocator #(
		.NUM_BLOCKS(BLOCKS),
		.SIZE_BITS (mfa_pkg::AMOUNT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	function automatic int unsigned draw_gap();
		if (steady || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	// Search the blocks in use under the current policy and shrink the one chosen.
	function automatic mfa_pkg::result_t serve_request(
			input logic [mfa_pkg::AMOUNT_BITS-1:0] need, input logic last);
		mfa_pkg::result_t r;
		int               n;
		int               pos;
		int               pick;
		logic             hit;
		r = '0;
		hit = 1'b0;
		pick = 0;
		n = (cur_count > BLOCKS) ? BLOCKS : int'(cur_count);
		if (cur_mode == mfa_pkg::FIT_NEXT) begin
			pos = (int'(next_ptr) < n) ? int'(next_ptr) : 0;
			for (int j = 0; j < n; j++) begin
				if (!hit) begin
					if (blk_free[pos] >= need) begin
						hit = 1'b1;
						pick = pos;
					end else begin
						pos = (pos + 1 == n) ? 0 : pos + 1;
					end
				end
			end
		end else begin
			for (int j = 0; j < n; j++) begin
				if (blk_free[j] >= need) begin
					if (!hit) begin
						hit = 1'b1;
						pick = j;
					end else if (cur_mode == mfa_pkg::FIT_BEST &&
							blk_free[j] <= blk_free[pick]) begin
						pick = j;
					end else if (cur_mode == mfa_pkg::FIT_WORST &&
							blk_free[j] > blk_free[pick]) begin
						pick = j;
					end
				end
			end
		end
		if (hit) begin
			blk_free[pick] = blk_free[pick] - need;
			if (cur_mode == mfa_pkg::FIT_NEXT)
				next_ptr = mfa_pkg::SLOT_BITS'(pick);
			r.granted = 1'b1;
			r.chosen_block = mfa_pkg::SLOT_BITS'(pick);
			r.left_over = blk_free[pick];
		end
		if (last)
			next_ptr = '0;
		return r;
	endfunction

	function automatic mfa_pkg::item_t random_item();
		mfa_pkg::item_t it;
		it.opcode = ($urandom_range(0, 9) < 3) ? mfa_pkg::OP_LOAD : mfa_pkg::OP_REQUEST;
		it.block_slot = mfa_pkg::SLOT_BITS'($urandom);
		it.last_request = ($urandom_range(0, 5) == 0);
		if (it.opcode == mfa_pkg::OP_LOAD) begin
			case ($urandom_range(0, 7))
				0: it.amount = '0;
				1: it.amount = '1;
				default: it.amount = mfa_pkg::AMOUNT_BITS'($urandom);
			endcase
		end else begin
			case ($urandom_range(0, 9))
				0: it.amount = '0;
				1: it.amount = '1;
				2, 3, 4, 5: it.amount = mfa_pkg::AMOUNT_BITS'($urandom_range(0, 255));
				6, 7: it.amount = mfa_pkg::AMOUNT_BITS'($urandom_range(0, 4095));
				default: it.amount = mfa_pkg::AMOUNT_BITS'($urandom);
			endcase
		end
		return it;
	endfunction

	function automatic void add_load(input int slot, input int amount, input logic last);
		plan_row_t row;
		row = '{default: '0};
		row.it.opcode = mfa_pkg::OP_LOAD;
		row.it.block_slot = mfa_pkg::SLOT_BITS'(slot);
		row.it.amount = mfa_pkg::AMOUNT_BITS'(amount);
		row.it.last_request = last;
		plan.push_back(row);
	endfunction

	function automatic void add_req(input int amount, input logic last, input logic typed,
			input logic g, input int blk, input int left);
		plan_row_t row;
		row = '{default: '0};
		row.it.opcode = mfa_pkg::OP_REQUEST;
		row.it.block_slot = mfa_pkg::SLOT_BITS'($urandom);
		row.it.amount = mfa_pkg::AMOUNT_BITS'(amount);
		row.it.last_request = last;
		row.typed = typed;
		row.want.granted = g;
		row.want.chosen_block = mfa_pkg::SLOT_BITS'(blk);
		row.want.left_over = mfa_pkg::AMOUNT_BITS'(left);
		plan.push_back(row);
	endfunction

	function automatic void add_cfg(input logic idx,
			input logic [mfa_pkg::COUNT_BITS-1:0] val);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		plan.push_back(row);
	endfunction

	task automatic push_item(input mfa_pkg::item_t it, input logic typed,
			input mfa_pkg::result_t want);
		int unsigned      gap;
		mfa_pkg::result_t calc;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= mfa_pkg::TDATA_BITS'({it.amount, it.block_slot});
		s_tuser <= it.opcode;
		s_tlast <= it.last_request;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (it.opcode == mfa_pkg::OP_LOAD) begin
			blk_free[it.block_slot] = it.amount;
			loads_sent++;
		end else begin
			calc = serve_request(it.amount, it.last_request);
			replies_due.push_back(typed ? want : calc);
			requests_sent++;
		end
	endtask

	task automatic set_register(input logic idx, input logic [mfa_pkg::COUNT_BITS-1:0] val);
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mfa_pkg::REG_FIT_MODE)
			cur_mode = mfa_pkg::fit_mode_t'(val[mfa_pkg::MODE_BITS-1:0]);
		else
			cur_count = val;
		cfg_writes++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_reply.granted = m_tuser[0];
			seen_reply.chosen_block = m_tdata[mfa_pkg::SLOT_BITS-1:0];
			seen_reply.left_over = m_tdata[mfa_pkg::SLOT_BITS +: mfa_pkg::AMOUNT_BITS];
			replies_checked++;
			if (seen_reply.granted === 1'b1)
				grants_seen++;
			if (replies_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected reply: granted=%0d block=%0d left=%0d",
						seen_reply.granted, seen_reply.chosen_block, seen_reply.left_over);
				mismatches++;
			end else begin
				due_reply = replies_due.pop_front();
				if (seen_reply.granted !== due_reply.granted
						|| seen_reply.chosen_block !== due_reply.chosen_block
						|| seen_reply.left_over !== due_reply.left_over) begin
					if (mismatches < 10)
						$display({"reply mismatch: expected granted=%0d block=%0d ",
							"left=%0d, got granted=%0d block=%0d left=%0d"},
							due_reply.granted, due_reply.chosen_block, due_reply.left_over,
							seen_reply.granted, seen_reply.chosen_block, seen_reply.left_over);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = hold_rx ? HOLD_CYCLES : draw_gap();
			hold_rx = 1'b0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid && !hold_rx) @(posedge clk);
		end
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("[memory_fit_allocator] ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= mfa_pkg::REG_FIT_MODE;
		cfg_data <= '0;
		for (int i = 0; i < BLOCKS; i++)
			blk_free[i] = '0;
		next_ptr = '0;
		cur_mode = mfa_pkg::FIT_FIRST;
		cur_count = mfa_pkg::BLOCKS_IN_USE_RESET;

		// Every block is loaded before the first request so no search reads an empty slot.
		add_load(0, 100, 1'b0);
		add_load(1, 0, 1'b0);
		add_load(2, 300, 1'b0);
		add_load(3, 300, 1'b0);
		add_load(4, 65535, 1'b0);
		add_load(5, 50, 1'b0);
		add_load(6, 300, 1'b0);
		add_load(7, 65535, 1'b0);
		add_req(65535, 1'b0, 1'b1, 1'b1, 4, 0);
		add_req(0, 1'b0, 1'b1, 1'b1, 0, 100);
		add_req(65535, 1'b0, 1'b1, 1'b1, 7, 0);
		add_req(65535, 1'b0, 1'b1, 1'b0, 0, 0);
		add_cfg(mfa_pkg::REG_FIT_MODE, mfa_pkg::COUNT_BITS'(mfa_pkg::FIT_BEST));
		add_req(300, 1'b0, 1'b1, 1'b1, 6, 0);
		add_req(60, 1'b0, 1'b1, 1'b1, 0, 40);
		add_cfg(mfa_pkg::REG_FIT_MODE, mfa_pkg::COUNT_BITS'(mfa_pkg::FIT_WORST));
		add_req(10, 1'b0, 1'b1, 1'b1, 2, 290);
		add_cfg(mfa_pkg::REG_FIT_MODE, mfa_pkg::COUNT_BITS'(mfa_pkg::FIT_NEXT));
		add_req(45, 1'b0, 1'b0, 1'b0, 0, 0);
		add_req(250, 1'b0, 1'b0, 1'b0, 0, 0);
		add_req(1000, 1'b0, 1'b1, 1'b0, 0, 0);
		add_req(50, 1'b1, 1'b0, 1'b0, 0, 0);
		add_req(40, 1'b0, 1'b0, 1'b0, 0, 0);
		add_load(5, 60, 1'b1);
		add_req(10, 1'b0, 1'b0, 1'b0, 0, 0);
		add_load(1, 20, 1'b0);
		add_cfg(mfa_pkg::REG_BLOCKS_IN_USE, 4'd2);
		add_req(5, 1'b0, 1'b0, 1'b0, 0, 0);
		add_cfg(mfa_pkg::REG_BLOCKS_IN_USE, 4'd0);
		add_req(0, 1'b0, 1'b1, 1'b0, 0, 0);
		add_cfg(mfa_pkg::REG_BLOCKS_IN_USE, 4'd15);
		add_req(235, 1'b0, 1'b0, 1'b0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_register(plan[i].reg_idx, plan[i].reg_val);
			else
				push_item(plan[i].it, plan[i].typed, plan[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			steady = (p == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
			set_register(mfa_pkg::REG_FIT_MODE, {2'($urandom), 2'(p % 4)});
			set_register(mfa_pkg::REG_BLOCKS_IN_USE, phase_counts[p]);
			if (p == HOLD_PHASE)
				hold_rx = 1'b1;
			repeat (PHASE_ITEMS) push_item(random_item(), 1'b0, '0);
		end

		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d loads and %0d requests over %0d register writes.",
			loads_sent, requests_sent, cfg_writes);
		$display("Checked %0d replies, %0d of them grants, %0d mismatching.",
			replies_checked, grants_seen, mismatches);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("[memory_fit_allocator] OK");
		else
			$display("[memory_fit_allocator] ERROR");
		$finish;
	end

endmodule
